FILE: hw/rtl/obp_pkg.sv
// shared types and constants for the online bin packer
package obp_pkg;

  localparam int ITEM_W    = 17;  // item size and bin level, 1.0 = 65536
  localparam int BIN_OUT_W = 6;   // bin_index field
  localparam int CNT_OUT_W = 7;   // bins_in_use field
  localparam int POL_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 17;

  localparam logic [ITEM_W-1:0] CAPACITY = 17'd65536;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_POLICY    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

  // placement policies
  localparam logic [POL_W-1:0] POL_BEST  = 2'd0;
  localparam logic [POL_W-1:0] POL_WORST = 2'd1;
  localparam logic [POL_W-1:0] POL_FIRST = 2'd2;

  // input commands
  localparam logic CMD_PLACE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } obp_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // take the input word
    logic scan_rd;  // read the next bin and advance the address
    logic commit;   // write back the chosen bin and load the result
  } obp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_scan;  // offered word is a place that needs a search
    logic scan_last;   // address on the read port is the last occupied bin
  } obp_sts_t;

endpackage

FILE: hw/rtl/obp_if.sv
// input and result channel interfaces of the online bin packer
interface obp_in_if import obp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [ITEM_W-1:0] item_size;

  modport source (output valid, output command, output item_size, input ready);
  modport sink   (input valid, input command, input item_size, output ready);
endinterface

interface obp_out_if import obp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [BIN_OUT_W-1:0] bin_index;
  logic                 opened_new;
  logic                 no_room;
  logic [ITEM_W-1:0]    new_level;
  logic [CNT_OUT_W-1:0] bins_in_use;

  modport source (output valid, output bin_index, output opened_new, output no_room,
                  output new_level, output bins_in_use, input ready);
  modport sink   (input valid, input bin_index, input opened_new, input no_room,
                  input new_level, input bins_in_use, output ready);
endinterface

FILE: hw/rtl/obp_ctrl.sv
// sequencing state machine of the online bin packer
module obp_ctrl import obp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  obp_sts_t sts,
  output obp_cmd_t cmd
);

  obp_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.start_scan ? ST_SCAN : ST_COMMIT;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.scan_rd = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/obp_dp.sv
// level memory, fit search and result registers of the online bin packer
module obp_dp import obp_pkg::*; #(
  parameter int NUM_BINS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_command,
  input  logic [ITEM_W-1:0]    in_item_size,
  input  obp_cmd_t             cmd,
  output obp_sts_t             sts,
  output logic [BIN_OUT_W-1:0] out_bin_index,
  output logic                 out_opened_new,
  output logic                 out_no_room,
  output logic [ITEM_W-1:0]    out_new_level,
  output logic [CNT_OUT_W-1:0] out_bins_in_use
);

  localparam int IDX_W = $clog2(NUM_BINS);
  localparam int CNT_W = $clog2(NUM_BINS + 1);
  localparam int SUM_W = ITEM_W + 1;

  // bin levels; occupied bins always form the prefix below count_r
  logic [ITEM_W-1:0] level_mem [NUM_BINS];

  logic [POL_W-1:0]  policy_r;
  logic [ITEM_W-1:0] threshold_r;
  logic              clear_r;
  logic [ITEM_W-1:0] item_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  addr_r;
  logic [ITEM_W-1:0] rd_level_r;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              found_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [ITEM_W-1:0] best_key_r;
  logic [ITEM_W-1:0] best_sum_r;

  logic [BIN_OUT_W-1:0] res_idx_r;
  logic                 res_opened_r;
  logic                 res_drop_r;
  logic [ITEM_W-1:0]    res_level_r;
  logic [CNT_OUT_W-1:0] res_count_r;

  logic [SUM_W-1:0]  sum;
  logic [ITEM_W-1:0] lim;
  logic [ITEM_W-1:0] rem;
  logic              cand;
  logic [ITEM_W-1:0] cand_key;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ITEM_W-1:0] wr_data;
  logic [IDX_W-1:0]  new_idx;
  logic              new_opened;
  logic              new_drop;
  logic [ITEM_W-1:0] new_level;

  // status
  assign sts.start_scan = (in_command == CMD_PLACE) && (in_item_size <= CAPACITY)
                          && (count_r != '0);
  assign sts.scan_last  = (CNT_W'(addr_r) == (count_r - CNT_W'(1)));

  // candidate test on the level read in the previous cycle
  assign sum = SUM_W'(rd_level_r) + SUM_W'(item_r);
  assign lim = (threshold_r > CAPACITY) ? CAPACITY : threshold_r;
  assign rem = ITEM_W'(SUM_W'(CAPACITY) - sum);

  always_comb begin
    cand     = 1'b0;
    cand_key = best_key_r;
    case (policy_r)
      POL_BEST: begin
        cand     = (sum > SUM_W'(best_key_r)) && (sum <= SUM_W'(lim));
        cand_key = sum[ITEM_W-1:0];
      end
      POL_WORST: begin
        cand     = (sum < SUM_W'(CAPACITY)) && (rem <= threshold_r) && (rem > best_key_r);
        cand_key = rem;
      end
      default: begin
        // first fit, also for the unused code
        cand = !found_r && (sum <= SUM_W'(CAPACITY));
      end
    endcase
  end

  // placement decision at commit
  always_comb begin
    new_idx    = '0;
    new_opened = 1'b0;
    new_drop   = 1'b0;
    new_level  = '0;
    count_nxt  = count_r;
    wr_en      = 1'b0;
    wr_addr    = best_idx_r;
    wr_data    = best_sum_r;
    if (clear_r) begin
      count_nxt = '0;
    end else if (item_r > CAPACITY) begin
      new_drop = 1'b1;
    end else if (found_r) begin
      new_idx   = best_idx_r;
      new_level = best_sum_r;
      wr_en     = 1'b1;
    end else if (count_r != CNT_W'(NUM_BINS)) begin
      new_idx    = count_r[IDX_W-1:0];
      new_opened = 1'b1;
      new_level  = item_r;
      count_nxt  = count_r + CNT_W'(1);
      wr_en      = 1'b1;
      wr_addr    = count_r[IDX_W-1:0];
      wr_data    = item_r;
    end else begin
      new_drop = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      level_mem[wr_addr] <= wr_data;
    end
    rd_level_r <= level_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POL_BEST;
      threshold_r <= CAPACITY;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == REG_POLICY)) begin
        policy_r <= cfg_wdata[POL_W-1:0];
      end
      if (cfg_we && (cfg_index == REG_THRESHOLD)) begin
        threshold_r <= cfg_wdata[ITEM_W-1:0];
      end
      if (cmd.commit) begin
        count_r <= count_nxt;
      end
      cmp_vld_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= addr_r;
    if (cmd.load) begin
      clear_r    <= in_command;
      item_r     <= in_item_size;
      addr_r     <= '0;
      found_r    <= 1'b0;
      best_key_r <= '0;
    end else begin
      if (cmd.scan_rd) begin
        addr_r <= addr_r + IDX_W'(1);
      end
      if (cmp_vld_r && cand) begin
        found_r    <= 1'b1;
        best_idx_r <= cmp_idx_r;
        best_key_r <= cand_key;
        best_sum_r <= sum[ITEM_W-1:0];
      end
    end
    if (cmd.commit) begin
      res_idx_r    <= BIN_OUT_W'(new_idx);
      res_opened_r <= new_opened;
      res_drop_r   <= new_drop;
      res_level_r  <= new_level;
      res_count_r  <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_bin_index   = res_idx_r;
  assign out_opened_new  = res_opened_r;
  assign out_no_room     = res_drop_r;
  assign out_new_level   = res_level_r;
  assign out_bins_in_use = res_count_r;

endmodule

FILE: hw/rtl/online_bin_packer.sv
// top level of the online bin packer: controller, datapath and channel hookup
//
//   channel  dir  handshake      word
//   in_ch    in   valid/ready    command, item_size
//   out_ch   out  valid/ready    bin_index, opened_new, no_room, new_level, bins_in_use
//   cfg_*    in   cfg_we only    cfg_index (0 policy, 1 threshold), cfg_wdata
//
// a place word is taken, then each occupied bin is read in turn from the level memory,
// the last compare is finished and the chosen bin, if any, is written back; clear,
// oversize and empty-packer words go straight from taking the word to the commit
// synchronous active-low reset clears the bin count, so no memory sweep is needed
// a finished word sits in the output register; a new input word is taken meanwhile,
// and the write-back waits only if the previous result is still not taken
module online_bin_packer import obp_pkg::*; #(
  parameter int NUM_BINS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  obp_in_if.sink               in_ch,
  obp_out_if.source            out_ch
);

  obp_cmd_t cmd;
  obp_sts_t sts;

  // state machine: accept, scan, drain, commit
  obp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // level memory, one bin compared per cycle, result register
  obp_dp #(
    .NUM_BINS (NUM_BINS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_command      (in_ch.command),
    .in_item_size    (in_ch.item_size),
    .cmd             (cmd),
    .sts             (sts),
    .out_bin_index   (out_ch.bin_index),
    .out_opened_new  (out_ch.opened_new),
    .out_no_room     (out_ch.no_room),
    .out_new_level   (out_ch.new_level),
    .out_bins_in_use (out_ch.bins_in_use)
  );

endmodule
